### src/hcb_pkg.sv
// Shared types and constants for the Huffman code builder.
package hcb_pkg;

  localparam int unsigned SymbolsDefault = 16;
  localparam int unsigned WeightW  = 20;
  localparam int unsigned TotalW   = 24;
  localparam logic [19:0] WeightMax = 20'hFFFFF;
  localparam logic [23:0] TotalMax  = 24'hFFFFFF;

  typedef struct packed {
    logic [7:0]  symbol;
    logic [15:0] weight;
    logic        final_leaf;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  leaf_symbol;
    logic [14:0] code_bits;
    logic [3:0]  code_length;
    logic [23:0] weighted_total;
    logic [19:0] root_weight;
    logic        overflow;
    logic        end_of_codes;
  } out_item_t;

endpackage

### src/hcb_front.sv
// Input stage: holds accepted leaf requests in a short queue for the core.
module hcb_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  hcb_pkg::in_item_t in_data_i,
  input  logic              in_push_i,
  output logic              in_full_o,
  output hcb_pkg::in_item_t req_data_o,
  output logic              req_valid_o,
  input  logic              req_take_i
);

  localparam int unsigned Depth = 2;

  hcb_pkg::in_item_t mem_q [Depth];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  logic       do_push, do_pop;

  assign in_full_o   = (cnt_q == 2'(Depth));
  assign req_valid_o = (cnt_q != 2'd0);
  assign req_data_o  = mem_q[rd_ptr_q];
  assign do_push     = in_push_i && !in_full_o;
  assign do_pop      = req_take_i && req_valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= in_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (do_push) wr_ptr_q <= ~wr_ptr_q;
      if (do_pop)  rd_ptr_q <= ~rd_ptr_q;
      cnt_q <= cnt_q + 2'(do_push) - 2'(do_pop);
    end
  end

endmodule

### src/hcb_core.sv
// Back end: ordered queue, tree merge and depth-first code walk.
module hcb_core #(
  parameter int unsigned Symbols = hcb_pkg::SymbolsDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  hcb_pkg::in_item_t  req_data_i,
  input  logic               req_valid_i,
  output logic               req_take_o,
  output hcb_pkg::out_item_t out_data_o,
  output logic               out_empty_o,
  input  logic               out_pop_i
);

  localparam int unsigned Nodes = 2 * Symbols - 1;
  localparam int unsigned NW    = $clog2(Nodes + 1);
  localparam int unsigned SW    = $clog2(Symbols + 1);
  localparam int unsigned SpW   = $clog2(Nodes + 2);
  localparam int unsigned StkW  = $clog2(Nodes + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_INS_RD, S_INS_CMP, S_TAKE_A, S_TAKE_B, S_MERGE,
    S_ROOT, S_POP, S_NODE, S_EMIT, S_WAIT
  } state_e;

  state_e state_q;

  logic [7:0]         sym_mem   [Symbols];
  logic [19:0]        wt_mem    [Nodes];
  logic [NW-1:0]      lc_mem    [Nodes];
  logic [NW-1:0]      rc_mem    [Nodes];
  logic [NW-1:0]      oq_mem    [Nodes];
  logic [NW-1:0]      stk_node  [Nodes + 1];
  logic [3:0]         stk_dep   [Nodes + 1];
  logic [14:0]        stk_code  [Nodes + 1];

  logic [NW-1:0]  head_q, tail_q, pos_q, next_q, ins_node_q, a_q, cur_q;
  logic [19:0]    ins_w_q, a_w_q, root_q;
  logic [SW-1:0]  leaf_cnt_q, n_q, count_q;
  logic           dropped_q, fin_q, build_q;
  logic [SpW-1:0] sp_q;
  logic [3:0]     dep_q;
  logic [14:0]    code_q;
  logic [23:0]    total_q;
  logic [20:0]    sum;
  logic [24:0]    tsum;
  logic [NW-1:0]  prev_node;
  logic [StkW-1:0] stk_top, stk_r, stk_l;
  logic           emit;

  hcb_pkg::out_item_t out_q;
  logic               out_v_q;

  assign out_data_o  = out_q;
  assign out_empty_o = !out_v_q;
  assign req_take_o  = (state_q == S_IDLE) && req_valid_i;
  assign prev_node   = oq_mem[pos_q - NW'(1)];
  assign sum         = {1'b0, a_w_q} + {1'b0, wt_mem[oq_mem[head_q]]};
  assign tsum        = {1'b0, total_q} +
                       25'({1'b0, wt_mem[cur_q]} * 21'(dep_q));
  assign stk_top     = StkW'(sp_q - SpW'(1));
  assign stk_r       = StkW'(sp_q);
  assign stk_l       = StkW'(sp_q + SpW'(1));
  assign emit        = (state_q == S_NODE) && (32'(cur_q) < 32'(n_q)) &&
                       (!out_v_q || out_pop_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      head_q     <= '0;
      tail_q     <= '0;
      leaf_cnt_q <= '0;
      dropped_q  <= 1'b0;
      out_v_q    <= 1'b0;
      fin_q      <= 1'b0;
      build_q    <= 1'b0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (req_valid_i) begin
            fin_q <= req_data_i.final_leaf;
            if (32'(leaf_cnt_q) < Symbols) begin
              sym_mem[leaf_cnt_q[$clog2(Symbols)-1:0]] <= req_data_i.symbol;
              wt_mem[NW'(leaf_cnt_q)] <= {4'd0, req_data_i.weight};
              ins_node_q <= NW'(leaf_cnt_q);
              ins_w_q    <= {4'd0, req_data_i.weight};
              pos_q      <= tail_q;
              leaf_cnt_q <= leaf_cnt_q + SW'(1);
              build_q    <= 1'b0;
              state_q    <= S_INS_CMP;
            end else begin
              dropped_q <= 1'b1;
              if (req_data_i.final_leaf) begin
                n_q <= leaf_cnt_q; next_q <= NW'(leaf_cnt_q);
                state_q <= S_TAKE_A;
              end
            end
          end
        end
        S_INS_CMP: begin
          // stable insertion: shift heavier entries back one slot
          if (pos_q > head_q && wt_mem[prev_node] > ins_w_q) begin
            oq_mem[pos_q] <= prev_node;
            pos_q <= pos_q - NW'(1);
          end else begin
            oq_mem[pos_q] <= ins_node_q;
            tail_q <= tail_q + NW'(1);
            if (build_q) begin
              next_q  <= next_q + NW'(1);
              state_q <= S_TAKE_A;
            end else if (fin_q) begin
              n_q <= leaf_cnt_q; next_q <= NW'(leaf_cnt_q);
              state_q <= S_TAKE_A;
            end else begin
              state_q <= S_IDLE;
            end
          end
        end
        S_TAKE_A: begin
          if (32'(next_q) < Nodes &&
              32'(next_q - NW'(n_q)) + 1 < 32'(n_q)) begin
            a_q    <= oq_mem[head_q];
            a_w_q  <= wt_mem[oq_mem[head_q]];
            head_q <= head_q + NW'(1);
            state_q <= S_TAKE_B;
          end else begin
            state_q <= S_ROOT;
          end
        end
        S_TAKE_B: begin
          wt_mem[next_q] <= sum[20] ? hcb_pkg::WeightMax : sum[19:0];
          lc_mem[next_q] <= a_q;
          rc_mem[next_q] <= oq_mem[head_q];
          ins_w_q    <= sum[20] ? hcb_pkg::WeightMax : sum[19:0];
          ins_node_q <= next_q;
          head_q     <= head_q + NW'(1);
          pos_q      <= tail_q;
          build_q    <= 1'b1;
          state_q    <= S_INS_CMP;
        end
        S_ROOT: begin
          stk_node[0] <= oq_mem[head_q];
          stk_dep[0]  <= 4'd0;
          stk_code[0] <= 15'd0;
          root_q      <= wt_mem[oq_mem[head_q]];
          sp_q        <= SpW'(1);
          total_q     <= '0;
          count_q     <= '0;
          state_q     <= S_POP;
        end
        S_POP: begin
          if (sp_q != '0 && 32'(count_q) < Symbols) begin
            cur_q  <= stk_node[stk_top];
            dep_q  <= stk_dep[stk_top];
            code_q <= stk_code[stk_top];
            sp_q   <= sp_q - SpW'(1);
            state_q <= S_NODE;
          end else begin
            head_q <= '0; tail_q <= '0; leaf_cnt_q <= '0; dropped_q <= 1'b0;
            state_q <= S_IDLE;
          end
        end
        S_NODE: begin
          if (32'(cur_q) < 32'(n_q)) begin
            if (emit) begin
              out_q.leaf_symbol    <= sym_mem[cur_q[$clog2(Symbols)-1:0]];
              out_q.code_bits      <= code_q;
              out_q.code_length    <= dep_q;
              out_q.weighted_total <= (tsum > 25'(hcb_pkg::TotalMax)) ?
                                      hcb_pkg::TotalMax : tsum[23:0];
              total_q <= (tsum > 25'(hcb_pkg::TotalMax)) ?
                         hcb_pkg::TotalMax : tsum[23:0];
              out_q.root_weight    <= root_q;
              out_q.overflow       <= dropped_q;
              out_q.end_of_codes   <= (sp_q == '0) ||
                                      (32'(count_q) + 1 >= Symbols);
              count_q <= count_q + SW'(1);
              state_q <= S_POP;
            end
          end else begin
            stk_node[stk_r] <= rc_mem[cur_q];
            stk_dep[stk_r]  <= (dep_q == 4'd15) ? 4'd15 : dep_q + 4'd1;
            stk_code[stk_r] <= {code_q[13:0], 1'b1};
            stk_node[stk_l] <= lc_mem[cur_q];
            stk_dep[stk_l]  <= (dep_q == 4'd15) ? 4'd15 : dep_q + 4'd1;
            stk_code[stk_l] <= {code_q[13:0], 1'b0};
            sp_q    <= sp_q + SpW'(2);
            state_q <= S_POP;
          end
        end
        default: state_q <= S_IDLE;
      endcase
      if (emit) out_v_q <= 1'b1;
      else if (out_pop_i && out_v_q) out_v_q <= 1'b0;
    end
  end

endmodule

### src/huffman_code_builder_top.sv
// A leaf passes through the input queue into the core, which inserts it in weight order.
// The final leaf starts a build of up to SYMBOLS-1 merges, each ending in an
// ordered-queue insertion that moves one slot per cycle.
// Code output walks the tree, one result per leaf; a held result stalls.
// Reset (async, low) empties the queues; stores need no clearing.
module huffman_code_builder_top #(
  parameter int unsigned SYMBOLS = hcb_pkg::SymbolsDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  hcb_pkg::in_item_t  in_data_i,
  input  logic               push,
  output logic               full,
  output hcb_pkg::out_item_t out_data_o,
  output logic               empty,
  input  logic               pop
);

  hcb_pkg::in_item_t req_data;
  logic              req_valid, req_take;

  hcb_front u_front (
    .clk_i, .rst_ni, .in_data_i, .in_push_i(push), .in_full_o(full),
    .req_data_o(req_data), .req_valid_o(req_valid), .req_take_i(req_take)
  );

  hcb_core #(.Symbols(SYMBOLS)) u_core (
    .clk_i, .rst_ni, .req_data_i(req_data), .req_valid_i(req_valid),
    .req_take_o(req_take), .out_data_o, .out_empty_o(empty), .out_pop_i(pop)
  );

endmodule

### src/hcb_checker.sv
// Port-level checker for the Huffman code builder, bound to the top level.
module hcb_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               empty,
  input logic               pop,
  input hcb_pkg::out_item_t out_data_o
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !pop |=> !empty && $stable(out_data_o)) else $error("result dropped");

  a_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && out_data_o.code_length == 4'd0 |-> out_data_o.end_of_codes)
    else $error("zero-length code not alone");

  a_total: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && out_data_o.code_length == 4'd0 |-> out_data_o.weighted_total == 24'd0)
    else $error("lone total nonzero");

endmodule

bind huffman_code_builder_top hcb_checker u_chk (
  .clk_i(clk_i), .rst_ni(rst_ni), .empty(empty), .pop(pop), .out_data_o(out_data_o)
);

### tb/huffman_code_builder_top_tb.sv
// Testbench for the Huffman code builder: random and directed leaf sets against a tree model.
`timescale 1ns / 1ps

module huffman_code_builder_top_tb;

  localparam int unsigned Symbols = hcb_pkg::SymbolsDefault;
  localparam int unsigned Nodes   = 2 * Symbols - 1;

  logic               clk_i;
  logic               rst_ni;
  hcb_pkg::in_item_t  in_data_i;
  logic               push;
  logic               full;
  hcb_pkg::out_item_t out_data_o;
  logic               empty;
  logic               pop;

  huffman_code_builder_top #(.SYMBOLS(Symbols)) dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .in_data_i(in_data_i), .push(push), .full(full),
    .out_data_o(out_data_o), .empty(empty), .pop(pop)
  );

  always begin
    clk_i = 1'b0; #5;
    clk_i = 1'b1; #5;
  end

  // Builder model state
  logic [7:0]  sym_store [Symbols];
  logic [19:0] node_wt [Nodes];
  int unsigned lchild [Nodes];
  int unsigned rchild [Nodes];
  int unsigned order_q [Nodes];
  int unsigned q_head, q_tail, n_leaves;
  bit          leaf_dropped;

  hcb_pkg::out_item_t code_queue[$];
  int unsigned mismatches, codes_seen, leaves_sent, runs_sent;
  bit          burst_mode;

  function automatic void order_insert(int unsigned node);
    int unsigned pos;
    pos = q_tail;
    if (q_tail >= Nodes) return;
    while (pos > q_head && node_wt[order_q[pos-1]] > node_wt[node]) begin
      order_q[pos] = order_q[pos-1];
      pos--;
    end
    order_q[pos] = node;
    q_tail++;
  endfunction

  function automatic int unsigned order_take();
    int unsigned node;
    node = 0;
    if (q_head < q_tail) begin
      node = order_q[q_head];
      q_head++;
    end
    return node;
  endfunction

  function automatic void predict_codes(hcb_pkg::in_item_t req);
    int unsigned nxt, a, b, sp, node, d, c, len, cnt;
    int unsigned stk_n [Nodes+1];
    int unsigned stk_d [Nodes+1];
    int unsigned stk_c [Nodes+1];
    logic [20:0] sum;
    logic [47:0] total;
    logic [19:0] root_w;
    hcb_pkg::out_item_t r;
    cnt = 0;
    total = '0;
    if (n_leaves < Symbols) begin
      sym_store[n_leaves] = req.symbol;
      node_wt[n_leaves] = {4'd0, req.weight};
      order_insert(n_leaves);
      n_leaves++;
    end else begin
      leaf_dropped = 1'b1;
    end
    if (!req.final_leaf) return;
    nxt = n_leaves;
    for (int unsigned k = 0; k + 1 < n_leaves && nxt < Nodes; k++) begin
      a = order_take();
      b = order_take();
      sum = node_wt[a] + node_wt[b];
      node_wt[nxt] = sum > hcb_pkg::WeightMax ? hcb_pkg::WeightMax : sum[19:0];
      lchild[nxt] = a;
      rchild[nxt] = b;
      order_insert(nxt);
      nxt++;
    end
    stk_n[0] = order_take();
    stk_d[0] = 0;
    stk_c[0] = 0;
    sp = 1;
    root_w = node_wt[stk_n[0]];
    while (sp > 0 && cnt < Symbols) begin
      sp--;
      node = stk_n[sp];
      d = stk_d[sp];
      c = stk_c[sp];
      if (node < n_leaves) begin
        len = d > 15 ? 15 : d;
        total = total + node_wt[node] * len;
        if (total > hcb_pkg::TotalMax) total = hcb_pkg::TotalMax;
        r.leaf_symbol    = sym_store[node];
        r.code_bits      = c[14:0];
        r.code_length    = len[3:0];
        r.weighted_total = total[23:0];
        r.root_weight    = root_w;
        r.overflow       = leaf_dropped;
        r.end_of_codes   = 1'b0;
        code_queue.push_back(r);
        cnt++;
      end else begin
        stk_n[sp] = rchild[node]; stk_d[sp] = d + 1; stk_c[sp] = ((c << 1) | 1) & 'h7FFF;
        sp++;
        stk_n[sp] = lchild[node]; stk_d[sp] = d + 1; stk_c[sp] = (c << 1) & 'h7FFF;
        sp++;
      end
    end
    if (cnt > 0) begin
      r = code_queue.pop_back();
      r.end_of_codes = 1'b1;
      code_queue.push_back(r);
    end
    q_head = 0;
    q_tail = 0;
    n_leaves = 0;
    leaf_dropped = 1'b0;
  endfunction

  // Send one leaf; gaps between bursts when burst_mode is on.
  // push stays high across back-to-back requests and is lowered in gaps.
  task automatic send_leaf(logic [7:0] s, logic [15:0] w, logic fin);
    hcb_pkg::in_item_t req;
    req.symbol = s;
    req.weight = w;
    req.final_leaf = fin;
    if (burst_mode && $urandom_range(0, 5) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    in_data_i <= req;
    push      <= 1'b1;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    predict_codes(req);
    leaves_sent++;
    if (fin) runs_sent++;
  endtask

  task automatic send_random_run(int unsigned cnt, int unsigned wmax);
    for (int unsigned i = 0; i < cnt; i++)
      send_leaf(8'($urandom_range(0, 255)), 16'($urandom_range(0, wmax)), i == cnt - 1);
  endtask

  task automatic wait_drained();
    while (code_queue.size() != 0) @(posedge clk_i);
  endtask

  task automatic test_extremes();
    send_leaf(8'hFF, 16'hFFFF, 1'b0);
    send_leaf(8'h00, 16'h0000, 1'b1);
    send_leaf(8'hA5, 16'hFFFF, 1'b1);  // lone symbol
    for (int i = 0; i < 16; i++)      // full set at max weight
      send_leaf(i[7:0] ^ 8'h5A, 16'hFFFF, i == 15);
  endtask

  task automatic test_ties_and_overflow();
    for (int i = 0; i < 4; i++) send_leaf(i[7:0], 16'd0, i == 3);  // all-zero ties
    for (int i = 0; i < 18; i++) send_leaf(8'h80 + i[7:0], 16'd1 << (i % 16), i == 17);
  endtask

  task automatic test_random();
    int unsigned n;
    while (leaves_sent < 210) begin
      burst_mode = $urandom_range(0, 3) != 0;
      case ($urandom_range(0, 9))
        0: n = $urandom_range(17, 20);  // too many leaves
        1: n = 16;
        default: n = $urandom_range(1, 8);
      endcase
      send_random_run(n, $urandom_range(0, 1) ? 65535 : 15);
    end
    burst_mode = 1'b0;
  endtask

  // Receiver stalls on its own pattern, with stretches where it never stalls.
  int unsigned pop_phase;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pop <= 1'b0;
      pop_phase <= 0;
    end else begin
      pop_phase <= pop_phase + 1;
      if (pop_phase[9:8] == 2'd0) pop <= 1'b1;
      else pop <= ($urandom_range(0, 3) != 0) && (pop_phase[2:0] != 3'd5);
    end
  end

  always @(posedge clk_i) begin
    hcb_pkg::out_item_t want;
    if (rst_ni && pop && !empty) begin
      codes_seen++;
      if (code_queue.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected code result %h", out_data_o);
      end else begin
        want = code_queue.pop_front();
        if (out_data_o !== want) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch: sym %h/%h bits %h/%h len %0d/%0d",
                     want.leaf_symbol, out_data_o.leaf_symbol,
                     want.code_bits, out_data_o.code_bits,
                     want.code_length, out_data_o.code_length);
            $display("  tot %0d/%0d root %0d/%0d ov %b/%b eoc %b/%b",
                     want.weighted_total, out_data_o.weighted_total,
                     want.root_weight, out_data_o.root_weight,
                     want.overflow, out_data_o.overflow,
                     want.end_of_codes, out_data_o.end_of_codes);
          end
        end
      end
    end
  end

  initial begin
    rst_ni = 1'b0;
    push = 1'b0;
    in_data_i = '0;
    q_head = 0; q_tail = 0; n_leaves = 0; leaf_dropped = 1'b0;
    mismatches = 0; codes_seen = 0; leaves_sent = 0; runs_sent = 0;
    burst_mode = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_extremes();
    test_ties_and_overflow();
    test_random();
    push <= 1'b0;
    wait_drained();
    repeat (200) @(posedge clk_i);
    $display("Sent %0d leaves in %0d code sets; checked %0d code results.",
             leaves_sent, runs_sent, codes_seen);
    if (mismatches == 0 && code_queue.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d mismatches, %0d results missing", mismatches, code_queue.size());
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("Timeout");
    $display("Simulation FAILED");
    $finish;
  end

endmodule
